[hdl/tmh_pkg.sv]
// Shared types, constants and SHA-256 helpers for the time-based port hop block.
package tmh_pkg;

    localparam int unsigned TimeW   = 64;
    localparam int unsigned PortW   = 16;
    localparam int unsigned CfgW    = 64;
    localparam int unsigned CfgAddrW = 3;

    localparam logic [CfgAddrW-1:0] REG_KEY0   = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_KEY1   = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_KEY2   = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_KEY3   = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_PERIOD = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_PLOW   = 3'd5;
    localparam logic [CfgAddrW-1:0] REG_PHIGH  = 3'd6;

    localparam logic [31:0] DEFAULT_PERIOD = 32'd60;
    localparam logic [15:0] RESET_PLOW     = 16'd1024;
    localparam logic [15:0] RESET_PHIGH    = 16'd65535;

    // block selectors for the four compressions
    localparam logic [1:0] BLK_IPAD  = 2'd0;
    localparam logic [1:0] BLK_MSG   = 2'd1;
    localparam logic [1:0] BLK_OPAD  = 2'd2;
    localparam logic [1:0] BLK_INNER = 2'd3;

    localparam logic [31:0] IPAD_WORD = 32'h36363636;
    localparam logic [31:0] OPAD_WORD = 32'h5c5c5c5c;
    localparam logic [31:0] PAD_WORD  = 32'h80000000;
    localparam logic [31:0] MSG_BITS  = 32'd576;
    localparam logic [31:0] DIG_BITS  = 32'd768;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [63:0] key0;
        logic [63:0] key1;
        logic [63:0] key2;
        logic [63:0] key3;
        logic [31:0] period;
        logic [15:0] port_low;
        logic [15:0] port_high;
    } cfg_t;

    typedef struct packed {
        logic       start_div;
        logic       start_sha;
        logic [1:0] blk;
        logic       start_mod;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic done;
    } stat_t;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIV  = 8'b0000_0010,
        ST_SHA0 = 8'b0000_0100,
        ST_SHA1 = 8'b0000_1000,
        ST_SHA2 = 8'b0001_0000,
        ST_SHA3 = 8'b0010_0000,
        ST_MOD  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    function automatic word_t sha_init(input logic [2:0] i);
        case (i)
            3'd0:    sha_init = 32'h6a09e667;
            3'd1:    sha_init = 32'hbb67ae85;
            3'd2:    sha_init = 32'h3c6ef372;
            3'd3:    sha_init = 32'ha54ff53a;
            3'd4:    sha_init = 32'h510e527f;
            3'd5:    sha_init = 32'h9b05688c;
            3'd6:    sha_init = 32'h1f83d9ab;
            default: sha_init = 32'h5be0cd19;
        endcase
    endfunction

    function automatic word_t sha_k(input logic [5:0] i);
        case (i)
            6'd0:  sha_k = 32'h428a2f98; 6'd1:  sha_k = 32'h71374491;
            6'd2:  sha_k = 32'hb5c0fbcf; 6'd3:  sha_k = 32'he9b5dba5;
            6'd4:  sha_k = 32'h3956c25b; 6'd5:  sha_k = 32'h59f111f1;
            6'd6:  sha_k = 32'h923f82a4; 6'd7:  sha_k = 32'hab1c5ed5;
            6'd8:  sha_k = 32'hd807aa98; 6'd9:  sha_k = 32'h12835b01;
            6'd10: sha_k = 32'h243185be; 6'd11: sha_k = 32'h550c7dc3;
            6'd12: sha_k = 32'h72be5d74; 6'd13: sha_k = 32'h80deb1fe;
            6'd14: sha_k = 32'h9bdc06a7; 6'd15: sha_k = 32'hc19bf174;
            6'd16: sha_k = 32'he49b69c1; 6'd17: sha_k = 32'hefbe4786;
            6'd18: sha_k = 32'h0fc19dc6; 6'd19: sha_k = 32'h240ca1cc;
            6'd20: sha_k = 32'h2de92c6f; 6'd21: sha_k = 32'h4a7484aa;
            6'd22: sha_k = 32'h5cb0a9dc; 6'd23: sha_k = 32'h76f988da;
            6'd24: sha_k = 32'h983e5152; 6'd25: sha_k = 32'ha831c66d;
            6'd26: sha_k = 32'hb00327c8; 6'd27: sha_k = 32'hbf597fc7;
            6'd28: sha_k = 32'hc6e00bf3; 6'd29: sha_k = 32'hd5a79147;
            6'd30: sha_k = 32'h06ca6351; 6'd31: sha_k = 32'h14292967;
            6'd32: sha_k = 32'h27b70a85; 6'd33: sha_k = 32'h2e1b2138;
            6'd34: sha_k = 32'h4d2c6dfc; 6'd35: sha_k = 32'h53380d13;
            6'd36: sha_k = 32'h650a7354; 6'd37: sha_k = 32'h766a0abb;
            6'd38: sha_k = 32'h81c2c92e; 6'd39: sha_k = 32'h92722c85;
            6'd40: sha_k = 32'ha2bfe8a1; 6'd41: sha_k = 32'ha81a664b;
            6'd42: sha_k = 32'hc24b8b70; 6'd43: sha_k = 32'hc76c51a3;
            6'd44: sha_k = 32'hd192e819; 6'd45: sha_k = 32'hd6990624;
            6'd46: sha_k = 32'hf40e3585; 6'd47: sha_k = 32'h106aa070;
            6'd48: sha_k = 32'h19a4c116; 6'd49: sha_k = 32'h1e376c08;
            6'd50: sha_k = 32'h2748774c; 6'd51: sha_k = 32'h34b0bcb5;
            6'd52: sha_k = 32'h391c0cb3; 6'd53: sha_k = 32'h4ed8aa4a;
            6'd54: sha_k = 32'h5b9cca4f; 6'd55: sha_k = 32'h682e6ff3;
            6'd56: sha_k = 32'h748f82ee; 6'd57: sha_k = 32'h78a5636f;
            6'd58: sha_k = 32'h84c87814; 6'd59: sha_k = 32'h8cc70208;
            6'd60: sha_k = 32'h90befffa; 6'd61: sha_k = 32'ha4506ceb;
            6'd62: sha_k = 32'hbef9a3f7; default: sha_k = 32'hc67178f2;
        endcase
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t ssig0(input word_t x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(input word_t x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

[hdl/tmh_ctrl.sv]
// Sequencer for divide, four SHA-256 compressions, modulo and result hand-off.
module tmh_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  tmh_pkg::stat_t stat,
    output tmh_pkg::cmd_t  cmd
);
    import tmh_pkg::*;

    state_t state_reg, state_next;
    logic   oval_reg, oval_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = oval_reg;

    always_comb begin
        state_next = state_reg;
        oval_next  = oval_reg & ~m_tready;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (stat.done) begin
                    cmd.start_sha = 1'b1;
                    cmd.blk       = BLK_IPAD;
                    state_next    = ST_SHA0;
                end
            end
            ST_SHA0: begin
                if (stat.done) begin
                    cmd.start_sha = 1'b1;
                    cmd.blk       = BLK_MSG;
                    state_next    = ST_SHA1;
                end
            end
            ST_SHA1: begin
                if (stat.done) begin
                    cmd.start_sha = 1'b1;
                    cmd.blk       = BLK_OPAD;
                    state_next    = ST_SHA2;
                end
            end
            ST_SHA2: begin
                if (stat.done) begin
                    cmd.start_sha = 1'b1;
                    cmd.blk       = BLK_INNER;
                    state_next    = ST_SHA3;
                end
            end
            ST_SHA3: begin
                if (stat.done) begin
                    cmd.start_mod = 1'b1;
                    state_next    = ST_MOD;
                end
            end
            ST_MOD: begin
                if (stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!oval_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    oval_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            oval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            oval_reg  <= oval_next;
        end
    end

endmodule

[hdl/tmh_dp.sv]
// Datapath: bit-serial divider, SHA-256 round unit, bit-serial modulo, result register.
module tmh_dp (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [63:0]   time_in,
    input  tmh_pkg::cfg_t  cfg,
    input  tmh_pkg::cmd_t  cmd,
    output tmh_pkg::stat_t stat,
    output logic [15:0]   hop_port
);
    import tmh_pkg::*;

    logic        div_run_reg, sha_run_reg, mod_run_reg, ff_reg, done_reg;
    logic [5:0]  cnt_reg;
    logic [1:0]  blk_reg;
    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [15:0] mq_reg, mrem_reg;
    logic [15:0] out_reg;
    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       w_reg [16];
    word_t       inner_reg [8];

    logic [31:0] period;
    logic [32:0] div_sh;
    logic        div_ge;
    logic [16:0] range17, mod_sh;
    logic        mod_ge;
    word_t       t1, t2, w_new;
    word_t       blk_w [16];
    word_t       h_sum [8];

    assign period  = (cfg.period == 32'd0) ? DEFAULT_PERIOD : cfg.period;
    assign div_sh  = {rem_reg, quo_reg[63]};
    assign div_ge  = (div_sh >= {1'b0, period});
    assign range17 = {1'b0, cfg.port_high} - {1'b0, cfg.port_low} + 17'd1;
    assign mod_sh  = {mrem_reg, mq_reg[15]};
    assign mod_ge  = (mod_sh >= range17);

    assign t1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + sha_k(cnt_reg) + w_reg[0];
    assign t2 = bsig0(v_reg[0]) + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2])
              ^ (v_reg[1] & v_reg[2]));
    assign w_new = w_reg[0] + ssig0(w_reg[1]) + w_reg[9] + ssig1(w_reg[14]);

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            h_sum[i] = h_reg[i] + v_reg[i];
        end
        for (int i = 0; i < 16; i++) begin
            blk_w[i] = '0;
        end
        case (cmd.blk)
            BLK_IPAD, BLK_OPAD: begin
                blk_w[0] = cfg.key0[63:32];
                blk_w[1] = cfg.key0[31:0];
                blk_w[2] = cfg.key1[63:32];
                blk_w[3] = cfg.key1[31:0];
                blk_w[4] = cfg.key2[63:32];
                blk_w[5] = cfg.key2[31:0];
                blk_w[6] = cfg.key3[63:32];
                blk_w[7] = cfg.key3[31:0];
                for (int i = 0; i < 16; i++) begin
                    blk_w[i] = blk_w[i] ^ ((cmd.blk == BLK_IPAD) ? IPAD_WORD : OPAD_WORD);
                end
            end
            BLK_MSG: begin
                blk_w[0]  = quo_reg[63:32];
                blk_w[1]  = quo_reg[31:0];
                blk_w[2]  = PAD_WORD;
                blk_w[15] = MSG_BITS;
            end
            default: begin
                for (int i = 0; i < 8; i++) begin
                    blk_w[i] = inner_reg[i];
                end
                blk_w[8]  = PAD_WORD;
                blk_w[15] = DIG_BITS;
            end
        endcase
    end

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_run_reg <= 1'b0;
            sha_run_reg <= 1'b0;
            mod_run_reg <= 1'b0;
            ff_reg      <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            done_reg <= 1'b0;
            ff_reg   <= 1'b0;
            cnt_reg  <= cnt_reg + 6'd1;
            if (cmd.start_div || cmd.start_sha || cmd.start_mod) begin
                cnt_reg <= '0;
            end
            if (cmd.start_div) div_run_reg <= 1'b1;
            if (cmd.start_sha) sha_run_reg <= 1'b1;
            if (cmd.start_mod) mod_run_reg <= 1'b1;
            if (div_run_reg && cnt_reg == 6'd63) begin
                div_run_reg <= 1'b0;
                done_reg    <= 1'b1;
            end
            if (sha_run_reg && cnt_reg == 6'd63) begin
                sha_run_reg <= 1'b0;
                ff_reg      <= 1'b1;
            end
            if (ff_reg) done_reg <= 1'b1;
            if (mod_run_reg && cnt_reg == 6'd15) begin
                mod_run_reg <= 1'b0;
                done_reg    <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.start_div) begin
            quo_reg <= time_in;
            rem_reg <= '0;
        end else if (div_run_reg) begin
            quo_reg <= {quo_reg[62:0], div_ge};
            rem_reg <= div_ge ? 32'(div_sh - {1'b0, period}) : div_sh[31:0];
        end

        if (cmd.start_sha) begin
            blk_reg <= cmd.blk;
            for (int i = 0; i < 16; i++) begin
                w_reg[i] <= blk_w[i];
            end
            for (int i = 0; i < 8; i++) begin
                if (cmd.blk == BLK_IPAD || cmd.blk == BLK_OPAD) begin
                    h_reg[i] <= sha_init(3'(i));
                    v_reg[i] <= sha_init(3'(i));
                end else begin
                    v_reg[i] <= h_reg[i];
                end
            end
        end else if (sha_run_reg) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end else if (ff_reg) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= h_sum[i];
                if (blk_reg == BLK_MSG) inner_reg[i] <= h_sum[i];
            end
        end

        if (cmd.start_mod) begin
            mq_reg   <= h_reg[0][31:16];
            mrem_reg <= '0;
        end else if (mod_run_reg) begin
            mq_reg   <= {mq_reg[14:0], 1'b0};
            mrem_reg <= mod_ge ? 16'(mod_sh - range17) : mod_sh[15:0];
        end

        if (cmd.load_out) begin
            out_reg <= (cfg.port_high < cfg.port_low) ? cfg.port_low
                                                      : cfg.port_low + mrem_reg;
        end
    end

    assign stat.done = done_reg;
    assign hop_port  = out_reg;

endmodule

[hdl/time_hmac_port_hop.sv]
// Top level of the HMAC-SHA256 time-based port hop block.
// Each request carries a Unix time in seconds and yields one hop port. The time is
// divided by hop_period_seconds (zero means 60), the epoch is run through
// HMAC-SHA256 under the 256-bit key, and the first 16 digest bits are reduced
// into [port_low, port_high] (port_low if port_high is below it). A request runs
// through a bit-serial divider, four SHA-256 compressions (64 rounds each on
// one shared round unit, then a fold into the hash state and a handoff), a
// bit-serial modulo, and then the output register is loaded. The next request
// can be taken in the same cycle as the result becomes valid.
// Requests are taken one at a time; the output register lets the next request
// start while a result waits, and a second finished result holds the input off.
module time_hmac_port_hop (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [63:0]                  s_tdata,   // [63:0] time_seconds
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // [15:0] hop_port
    input  logic                         cfg_wr_en,
    input  logic [tmh_pkg::CfgAddrW-1:0] cfg_addr,
    input  logic [tmh_pkg::CfgW-1:0]     cfg_wr_data
);
    import tmh_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.key0      <= '0;
            cfg_reg.key1      <= '0;
            cfg_reg.key2      <= '0;
            cfg_reg.key3      <= '0;
            cfg_reg.period    <= DEFAULT_PERIOD;
            cfg_reg.port_low  <= RESET_PLOW;
            cfg_reg.port_high <= RESET_PHIGH;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_KEY0:   cfg_reg.key0      <= cfg_wr_data;
                REG_KEY1:   cfg_reg.key1      <= cfg_wr_data;
                REG_KEY2:   cfg_reg.key2      <= cfg_wr_data;
                REG_KEY3:   cfg_reg.key3      <= cfg_wr_data;
                REG_PERIOD: cfg_reg.period    <= cfg_wr_data[31:0];
                REG_PLOW:   cfg_reg.port_low  <= cfg_wr_data[15:0];
                REG_PHIGH:  cfg_reg.port_high <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    tmh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tmh_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .time_in  (s_tdata),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .stat     (stat),
        .hop_port (m_tdata)
    );

endmodule
